### rtl/ubh_pkg.sv
package ubh_pkg;

	// command codes
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_RANGE_LOW = 2'd0;
	localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
	localparam logic [1:0] REG_BINS_USED = 2'd2;

	// configuration reset values
	localparam logic [31:0] RANGE_LOW_RST = 32'd39322;  // ~0.6 in Q16.16
	localparam logic [30:0] BIN_WIDTH_RST = 31'd66;     // ~0.001 in Q16.16
	localparam logic [10:0] BINS_USED_RST = 11'd1000;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MULT,
		ST_CMP,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // take the input beat
		logic mult;       // register bins_used * bin_width
		logic cmp;        // range check, set up divider
		logic tot_inc;    // saturating bump of the sample total
		logic clr_total;  // zero the sample total
		logic div_step;   // one quotient bit
		logic mem_rd;     // issue counter read
		logic upd;        // consume read data, write back on add
		logic sweep;      // write zero to one counter, advance
		logic emit;       // load the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;         // sample lands in a bin in use
		logic div_last;    // final quotient bit this cycle
		logic sweep_last;  // last counter of the sweep this cycle
		logic out_free;    // output register can take a beat
	} dp_sts_t;

endpackage

### rtl/ubh_ram.sv
module ubh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ubh_ctrl.sv
module ubh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            command,
	output logic                  in_stall,
	output ubh_pkg::ctrl_cmd_t    cmd,
	input  ubh_pkg::dp_sts_t      sts
);

	ubh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ubh_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ubh_pkg::ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ubh_pkg::ST_IDLE;
				end
			end
			ubh_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (command)
						ubh_pkg::CMD_ADD:   state_d = ubh_pkg::ST_MULT;
						ubh_pkg::CMD_READ:  state_d = ubh_pkg::ST_RD;
						ubh_pkg::CMD_CLEAR: begin
							cmd.clr_total = 1'b1;
							state_d       = ubh_pkg::ST_CLEAR;
						end
						default:            state_d = ubh_pkg::ST_DONE;
					endcase
				end
			end
			ubh_pkg::ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ubh_pkg::ST_CMP;
			end
			ubh_pkg::ST_CMP: begin
				cmd.cmp     = 1'b1;
				cmd.tot_inc = 1'b1;
				state_d     = sts.hit ? ubh_pkg::ST_DIV : ubh_pkg::ST_DONE;
			end
			ubh_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ubh_pkg::ST_RD;
				end
			end
			ubh_pkg::ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ubh_pkg::ST_UPD;
			end
			ubh_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ubh_pkg::ST_DONE;
			end
			ubh_pkg::ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ubh_pkg::ST_DONE;
				end
			end
			ubh_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ubh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ubh_pkg::ST_IDLE;
			end
		endcase
	end

	// result only lands when the output register has room
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over an untaken beat");

	// no new beat while the counter store is being swept
	a_sweep_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> in_stall)
		else $error("input open during sweep");

endmodule

### rtl/ubh_dp.sv
module ubh_dp #(
	parameter int MAX_BINS    = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	// input item
	input  logic [1:0]                command,
	input  logic signed [31:0]        sample_value,
	input  logic [9:0]                read_index,
	// result
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [31:0]               bin_value,
	output logic [31:0]               grand_total,
	output logic [9:0]                hit_bin,
	output logic                      in_range,
	// control
	input  ubh_pkg::ctrl_cmd_t        cmd,
	output ubh_pkg::dp_sts_t          sts
);

	localparam int IDX_W  = $clog2(MAX_BINS);
	localparam int USED_W = $clog2(MAX_BINS + 1);
	localparam int PW     = USED_W + 31;   // bins_used * bin_width
	localparam int DW     = 32 + IDX_W;    // shifted divisor
	localparam int KW     = $clog2(IDX_W + 1);

	// configuration registers
	logic [31:0] range_low_q;
	logic [30:0] bin_width_q;
	logic [10:0] bins_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= ubh_pkg::RANGE_LOW_RST;
			bin_width_q <= ubh_pkg::BIN_WIDTH_RST;
			bins_used_q <= ubh_pkg::BINS_USED_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ubh_pkg::REG_RANGE_LOW: range_low_q <= cfg_data;
				ubh_pkg::REG_BIN_WIDTH: bin_width_q <= cfg_data[30:0];
				ubh_pkg::REG_BINS_USED: bins_used_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// item registers
	logic [1:0]              cmd_q;
	logic signed [32:0]      diff_q;
	logic [USED_W-1:0]       used_q;
	logic [IDX_W-1:0]        ridx_q;
	logic                    oob_q;
	logic [PW-1:0]           prod_q;

	logic [31:0]             used_ext;
	logic [31:0]             ridx_ext;

	always_comb begin
		used_ext = (32'(bins_used_q) > 32'(MAX_BINS)) ? 32'(MAX_BINS) : 32'(bins_used_q);
		ridx_ext = 32'(read_index);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			diff_q <= 33'(sample_value) - 33'($signed(range_low_q));
			used_q <= used_ext[USED_W-1:0];
			ridx_q <= ridx_ext[IDX_W-1:0];
			oob_q  <= ridx_ext >= 32'(MAX_BINS);
		end
		if (cmd.mult) begin
			prod_q <= PW'(used_q) * PW'(bin_width_q);
		end
	end

	// hit iff 0 <= diff < used * width; covers zero width and zero bins too
	logic hit_c;
	assign hit_c = !diff_q[32] && (PW'(diff_q[31:0]) < prod_q);

	// restoring divider, one quotient bit per cycle, MSB first
	logic [31:0]      rem_q;
	logic [DW-1:0]    dvs_q;
	logic [IDX_W-1:0] quot_q;
	logic [KW-1:0]    k_q;
	logic             ge_c;

	assign ge_c = DW'(rem_q) >= dvs_q;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			rem_q  <= diff_q[31:0];
			dvs_q  <= DW'(bin_width_q) << (IDX_W - 1);
			quot_q <= '0;
			k_q    <= KW'(IDX_W - 1);
		end else if (cmd.div_step) begin
			if (ge_c) begin
				rem_q <= rem_q - dvs_q[31:0];
			end
			dvs_q  <= dvs_q >> 1;
			quot_q <= (quot_q << 1) | IDX_W'(ge_c);
			k_q    <= k_q - KW'(1);
		end
	end

	// counter store
	logic [IDX_W-1:0]       clr_addr_q;
	logic                   sweep_last_c;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]       ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic                   add_upd;

	assign sweep_last_c = clr_addr_q == IDX_W'(MAX_BINS - 1);
	assign cnt_inc      = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
	assign add_upd      = cmd.upd && (cmd_q == ubh_pkg::CMD_ADD);

	always_comb begin
		ram_we    = cmd.sweep || add_upd;
		ram_waddr = cmd.sweep ? clr_addr_q : quot_q;
		ram_wdata = cmd.sweep ? '0 : cnt_inc;
		ram_raddr = (cmd_q == ubh_pkg::CMD_ADD) ? quot_q : ridx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.sweep) begin
			clr_addr_q <= sweep_last_c ? '0 : clr_addr_q + IDX_W'(1);
		end
	end

	ubh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (MAX_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.mem_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sample total
	logic [COUNT_WIDTH-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.clr_total) begin
			total_q <= '0;
		end else if (cmd.tot_inc && (total_q != '1)) begin
			total_q <= total_q + COUNT_WIDTH'(1);
		end
	end

	// staged result
	logic [COUNT_WIDTH-1:0] res_bin_q;
	logic [IDX_W-1:0]       res_hit_q;
	logic                   res_inr_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_bin_q <= '0;
			res_hit_q <= '0;
			res_inr_q <= 1'b0;
		end else if (add_upd) begin
			res_bin_q <= cnt_inc;
			res_hit_q <= quot_q;
			res_inr_q <= 1'b1;
		end else if (cmd.upd) begin
			res_bin_q <= oob_q ? '0 : ram_rdata;
		end
	end

	// output register
	logic [63:0] res_bin_ext;
	logic [63:0] total_ext;
	logic [31:0] res_hit_ext;

	assign res_bin_ext = 64'(res_bin_q);
	assign total_ext   = 64'(total_q);
	assign res_hit_ext = 32'(res_hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			bin_value   <= res_bin_ext[31:0];
			grand_total <= total_ext[31:0];
			hit_bin     <= res_hit_ext[9:0];
			in_range    <= res_inr_q;
		end
	end

	always_comb begin
		sts.hit        = hit_c;
		sts.div_last   = k_q == '0;
		sts.sweep_last = sweep_last_c;
		sts.out_free   = !out_valid || !out_stall;
	end

	// the divider must land below the bins in use
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		add_upd |-> (USED_W'(quot_q) < used_q))
		else $error("bin index out of range after divide");

	// total only moves down on a clear
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clr_total |=> total_q >= $past(total_q))
		else $error("sample total dropped without clear");

	// an add write-back is never zero
	a_inc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		add_upd |-> (ram_wdata != '0))
		else $error("zero written back on add");

endmodule

### rtl/uniform_bin_histogram_core.sv
// One beat is worked at a time: in_stall is high from acceptance until the result is loaded
// into the output register, and that load waits while the register holds an untaken beat.
// The divider (one quotient bit per cycle) sets the add rate, the zero sweep of all MAX_BINS
// counters in the counter RAM sets the clear rate.
// Reset (arst_n, async low): config to defaults, total zero, then a sweep of all MAX_BINS
// counters zeroes the counter RAM with in_stall high; config writes are taken throughout.
module uniform_bin_histogram_core #(
	parameter int MAX_BINS    = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] sample_value,
	input  logic [9:0]         read_index,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        bin_value,
	output logic [31:0]        grand_total,
	output logic [9:0]         hit_bin,
	output logic               in_range
);

	// Controller walks one beat at a time:
	//   add:   MULT (bins_used*bin_width) -> CMP (range check, total++; a miss goes to DONE)
	//          -> DIV for log2(MAX_BINS) quotient bits -> RD -> UPD (saturating write-back) -> DONE
	//   read:  RD -> UPD -> DONE
	//   clear: sweep every counter to zero -> DONE
	// DONE waits for the output register; the next beat is accepted while a result is held.
	ubh_pkg::ctrl_cmd_t ctrl_cmd;
	ubh_pkg::dp_sts_t   dp_sts;

	ubh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.cmd      (ctrl_cmd),
		.sts      (dp_sts)
	);

	// Datapath: config regs, range compare against the registered product (a sample is in
	// range iff 0 <= value-low < used*width, so the quotient fits the bin index), restoring
	// divider, counter RAM with registered read, saturating total and output register.
	ubh_dp #(
		.MAX_BINS    (MAX_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.sample_value (sample_value),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bin_value    (bin_value),
		.grand_total  (grand_total),
		.hit_bin      (hit_bin),
		.in_range     (in_range),
		.cmd          (ctrl_cmd),
		.sts          (dp_sts)
	);

	// a held result beat must not be overwritten before it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output beat dropped under stall");

endmodule

### verif/uniform_bin_histogram_core_tb.sv
`timescale 1ns / 100ps

module uniform_bin_histogram_core_tb;

	// command 3 is not decoded by the core; it must answer with the current total only
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NUM_BINS = 1024;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] sample;
		logic [9:0]  index;
	} beat_t;

	typedef struct packed {
		logic [31:0] bin_value;
		logic [31:0] grand_total;
		logic [9:0]  hit_bin;
		logic        in_range;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic signed [31:0] sample_value = '0;
	logic [9:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] bin_value;
	logic [31:0] grand_total;
	logic [9:0] hit_bin;
	logic in_range;

	// histogram mirror: counters, total and the register copy
	logic [31:0] bin_tally [NUM_BINS];
	logic [31:0] sample_total;
	logic signed [31:0] low_cfg;
	logic [30:0] width_cfg;
	logic [10:0] used_cfg;

	beat_t queued_beats[$];
	tally_t predicted_tallies[$];
	int beats_sent = 0;
	int beats_taken = 0;
	int error_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit beat_taken = 1'b0;
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;

	uniform_bin_histogram_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.sample_value(sample_value),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bin_value(bin_value),
		.grand_total(grand_total),
		.hit_bin(hit_bin),
		.in_range(in_range)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Bin lookup and counter update for one accepted beat. The bin index is the
	// exact floor of (sample - low) / width in 64-bit math; no rounding anywhere.
	task automatic tally_beat(input beat_t b, output tally_t t);
		longint offset;
		longint slot;
		longint used_eff;
		t = '0;
		case (b.command)
			ubh_pkg::CMD_ADD: begin
				offset = longint'($signed(b.sample)) - longint'(low_cfg);
				used_eff = (used_cfg > NUM_BINS) ? NUM_BINS : longint'(used_cfg);
				// below range and zero width both miss; total still counts
				if (offset >= 0 && width_cfg != 0) begin
					slot = offset / longint'(width_cfg);
					if (slot < used_eff) begin
						if (bin_tally[slot] != '1)
							bin_tally[slot]++;
						t.bin_value = bin_tally[slot];
						t.hit_bin = slot[9:0];
						t.in_range = 1'b1;
					end
				end
				if (sample_total != '1)
					sample_total++;
			end
			ubh_pkg::CMD_READ: t.bin_value = bin_tally[b.index];
			ubh_pkg::CMD_CLEAR: begin
				foreach (bin_tally[i])
					bin_tally[i] = '0;
				sample_total = '0;
			end
			default: ;
		endcase
		t.grand_total = sample_total;
	endtask

	// Sample aimed at the bins in use most of the time, at the bin edges some
	// of the time, anywhere otherwise.
	function automatic logic [31:0] aim_sample();
		longint v;
		longint used_eff;
		longint span_end;
		int unsigned pick;
		used_eff = (used_cfg > NUM_BINS) ? NUM_BINS : longint'(used_cfg);
		span_end = longint'(low_cfg) + used_eff * longint'(width_cfg);
		pick = $urandom_range(0, 99);
		if (pick < 65 && used_eff != 0 && width_cfg != 0)
			v = longint'(low_cfg)
				+ longint'($urandom_range(0, 32'(used_eff - 1))) * longint'(width_cfg)
				+ longint'($urandom_range(0, 32'(width_cfg - 31'd1)));
		else if (pick < 85) begin
			case ($urandom_range(0, 3))
				0: v = longint'(low_cfg) - 1;
				1: v = longint'(low_cfg);
				2: v = span_end - 1;
				default: v = span_end;
			endcase
		end else
			v = longint'($signed($urandom));
		if (v > 64'sd2147483647 || v < -64'sd2147483648)
			v = longint'($signed($urandom));
		return v[31:0];
	endfunction

	task automatic queue_beat(input logic [1:0] cmd, input logic [31:0] value,
			input logic [9:0] idx);
		beat_t b;
		b.command = cmd;
		b.sample = value;
		b.index = idx;
		queued_beats = {queued_beats, b};
	endtask

	// registers only change while the core is idle, so the mirror updates at once
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			ubh_pkg::REG_RANGE_LOW: low_cfg = data;
			ubh_pkg::REG_BIN_WIDTH: width_cfg = data[30:0];
			ubh_pkg::REG_BINS_USED: used_cfg = data[10:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait until every queued beat went in and every result came back
	task automatic drain();
		do
			@(negedge clk);
		while (queued_beats.size() != 0 || beats_taken != beats_sent
			|| predicted_tallies.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Input driver: a beat is held until taken, then the drawn gap is idled out.
	always @(negedge clk) begin
		beat_t b;
		if (arst_n) begin
			if (!in_valid || beat_taken) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (queued_beats.size() > 0) begin
					b = queued_beats.pop_front();
					command <= b.command;
					sample_value <= b.sample;
					read_index <= b.index;
					in_valid <= 1'b1;
					beats_sent++;
				end else
					in_valid <= 1'b0;
			end
			beat_taken = 1'b0;
		end
	end

	// Input monitor: every taken beat is run through the mirror right away.
	always @(posedge clk) begin
		beat_t b;
		tally_t t;
		if (arst_n && in_valid && !in_stall) begin
			b.command = command;
			b.sample = sample_value;
			b.index = read_index;
			tally_beat(b, t);
			predicted_tallies = {predicted_tallies, t};
			beats_taken++;
			beat_taken = 1'b1;
			send_gap = idle_on ? $urandom_range(0, 4) : 0;
		end
	end

	// Output stall: counted only while a result is waiting, so it really backs up.
	always @(negedge clk) begin
		if (out_valid === 1'b1 && stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else
			out_stall <= 1'b0;
	end

	// Output monitor: compare each taken result with the oldest prediction.
	always @(posedge clk) begin
		tally_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (predicted_tallies.size() == 0)
				flag_error("result beat with nothing outstanding");
			else begin
				want = predicted_tallies.pop_front();
				if (bin_value !== want.bin_value)
					flag_error($sformatf("bin_value %0h, want %0h", bin_value,
						want.bin_value));
				if (grand_total !== want.grand_total)
					flag_error($sformatf("grand_total %0h, want %0h", grand_total,
						want.grand_total));
				if (hit_bin !== want.hit_bin)
					flag_error($sformatf("hit_bin %0d, want %0d", hit_bin, want.hit_bin));
				if (in_range !== want.in_range)
					flag_error($sformatf("in_range %b, want %b", in_range, want.in_range));
			end
			stall_left = stall_on ? $urandom_range(0, 4) : 0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				predicted_tallies.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [31:0] junk;
		logic [31:0] pick;
		logic [31:0] value;
		logic [9:0] idx;
		int used_eff;

		foreach (bin_tally[i])
			bin_tally[i] = '0;
		sample_total = '0;
		low_cfg = ubh_pkg::RANGE_LOW_RST;
		width_cfg = ubh_pkg::BIN_WIDTH_RST;
		used_cfg = ubh_pkg::BINS_USED_RST;

		// reset; the core then sweeps its counter RAM with in_stall high
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: bin edges, below range, past the last bin, field extremes
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd0);
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd1023);
		queue_beat(ubh_pkg::CMD_ADD, ubh_pkg::RANGE_LOW_RST, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, ubh_pkg::RANGE_LOW_RST - 32'd1, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, ubh_pkg::RANGE_LOW_RST + 32'd65, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, ubh_pkg::RANGE_LOW_RST + 32'd65934, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, ubh_pkg::RANGE_LOW_RST + 32'd66000, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, 32'h7fffffff, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, 32'h80000000, 10'($urandom));
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd0);
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd999);
		queue_beat(CMD_UNUSED, $urandom, 10'($urandom));
		queue_beat(ubh_pkg::CMD_CLEAR, $urandom, 10'($urandom));
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd0);
		drain();

		// lowest edge, unit width, bins_used above the array (clamps to 1024)
		junk = $urandom;
		write_reg(ubh_pkg::REG_RANGE_LOW, 32'h80000000);
		write_reg(ubh_pkg::REG_BIN_WIDTH, {junk[31], 31'd1});
		write_reg(ubh_pkg::REG_BINS_USED, {junk[31:11], 11'd2047});
		queue_beat(ubh_pkg::CMD_ADD, 32'h80000000, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, 32'h800003ff, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, 32'h80000400, 10'($urandom));
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd1023);
		drain();

		// zero width: nothing lands
		write_reg(ubh_pkg::REG_BIN_WIDTH, 32'd0);
		queue_beat(ubh_pkg::CMD_ADD, 32'h80000000, 10'($urandom));
		drain();

		// widest bin, single bin in use
		write_reg(ubh_pkg::REG_RANGE_LOW, 32'd0);
		write_reg(ubh_pkg::REG_BIN_WIDTH, 32'h7fffffff);
		write_reg(ubh_pkg::REG_BINS_USED, 32'd1);
		queue_beat(ubh_pkg::CMD_ADD, 32'h7ffffffe, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, 32'h7fffffff, 10'($urandom));
		drain();

		// zero bins in use
		write_reg(ubh_pkg::REG_BINS_USED, 32'd0);
		queue_beat(ubh_pkg::CMD_ADD, 32'h00000005, 10'($urandom));
		drain();

		// highest edge: only the top value is in range
		write_reg(ubh_pkg::REG_RANGE_LOW, 32'h7fffffff);
		write_reg(ubh_pkg::REG_BIN_WIDTH, 32'd1);
		write_reg(ubh_pkg::REG_BINS_USED, 32'd1024);
		queue_beat(ubh_pkg::CMD_ADD, 32'h7fffffff, 10'($urandom));
		queue_beat(ubh_pkg::CMD_ADD, 32'h7ffffffe, 10'($urandom));
		queue_beat(ubh_pkg::CMD_READ, $urandom, 10'd0);
		drain();

		// random phases, each under its own setting
		for (int phase = 0; phase < 5; phase++) begin
			junk = $urandom;
			idle_on = (phase != 2);
			stall_on = (phase != 2);
			case (phase)
				0: begin
					write_reg(ubh_pkg::REG_RANGE_LOW,
						$urandom_range(0, 32'h200000) - 32'h100000);
					write_reg(ubh_pkg::REG_BIN_WIDTH,
						{junk[31], 31'($urandom_range(1, 4096))});
					write_reg(ubh_pkg::REG_BINS_USED,
						{junk[31:11], 11'($urandom_range(1, 1024))});
				end
				1: begin
					// few narrow bins: counts climb high
					write_reg(ubh_pkg::REG_RANGE_LOW, $urandom);
					write_reg(ubh_pkg::REG_BIN_WIDTH, $urandom_range(1, 3));
					write_reg(ubh_pkg::REG_BINS_USED, 32'd16);
				end
				2: begin
					write_reg(ubh_pkg::REG_RANGE_LOW, ubh_pkg::RANGE_LOW_RST);
					write_reg(ubh_pkg::REG_BIN_WIDTH, 32'(ubh_pkg::BIN_WIDTH_RST));
					write_reg(ubh_pkg::REG_BINS_USED, 32'(ubh_pkg::BINS_USED_RST));
				end
				3: begin
					write_reg(ubh_pkg::REG_RANGE_LOW, $urandom);
					write_reg(ubh_pkg::REG_BIN_WIDTH, $urandom);
					write_reg(ubh_pkg::REG_BINS_USED, $urandom);
				end
				default: begin
					write_reg(ubh_pkg::REG_RANGE_LOW,
						32'h80000000 + $urandom_range(0, 32'hffff));
					write_reg(ubh_pkg::REG_BIN_WIDTH, $urandom_range(32'h100000, 32'h400000));
					write_reg(ubh_pkg::REG_BINS_USED, 32'd1024);
				end
			endcase
			used_eff = (used_cfg > NUM_BINS) ? NUM_BINS : int'(used_cfg);
			for (int n = 0; n < 130; n++) begin
				pick = $urandom_range(0, 99);
				value = $urandom;
				idx = 10'($urandom);
				if (used_eff != 0 && $urandom_range(0, 9) < 7)
					idx = 10'($urandom_range(0, used_eff - 1));
				if (pick < 68)
					queue_beat(ubh_pkg::CMD_ADD, aim_sample(), idx);
				else if (pick < 93)
					queue_beat(ubh_pkg::CMD_READ, value, idx);
				else if (pick < 97)
					queue_beat(CMD_UNUSED, value, idx);
				else
					queue_beat(ubh_pkg::CMD_CLEAR, value, idx);
				// hold the sender mid-phase until the core has emptied out
				if (n == 64)
					drain();
			end
			drain();
		end

		repeat (40) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
